FILE: hdl/sector_box_visibility_test_top_defines.svh
// assertion macros for the sector box visibility test
`ifndef SECTOR_BOX_VISIBILITY_TEST_TOP_DEFINES_SVH
`define SECTOR_BOX_VISIBILITY_TEST_TOP_DEFINES_SVH

// same-cycle implication
`define SBVT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBVT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sbvt_pkg.sv
// shared types, constants and helper functions of the sector box test
`timescale 1ns / 1ps
`default_nettype none
package sbvt_pkg;

  localparam int COORD_W       = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int ROOT_W        = 35;
  localparam int RAD_W         = 2 * ROOT_W;
  localparam int SQRT_STAGES   = ROOT_W;
  localparam int CW            = 54;
  localparam int ZW            = 26;
  localparam int LAT_W         = 38;
  localparam int SCORE_W       = 40;
  localparam int BOX_W         = 6 * COORD_W;
  localparam int OUT_W         = 48;

  localparam logic [15:0] HALF_FULL  = 16'd46080;
  localparam logic [14:0] K035       = 15'd22938;
  localparam logic [31:0] HALF_ROUND = 32'd32768;
  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);

  localparam logic [2:0] REG_VIEW_X    = 3'd0;
  localparam logic [2:0] REG_VIEW_Y    = 3'd1;
  localparam logic [2:0] REG_SUBJECT_X = 3'd2;
  localparam logic [2:0] REG_SUBJECT_Y = 3'd3;
  localparam logic [2:0] REG_SUBJECT_Z = 3'd4;
  localparam logic [2:0] REG_FORWARD_X = 3'd5;
  localparam logic [2:0] REG_FORWARD_Y = 3'd6;
  localparam logic [2:0] REG_HALF_ANG  = 3'd7;

  typedef struct packed {
    logic                    bv;
    logic                    near;
    logic [RAD_W-1:0]        dist_rad;
    logic [RAD_W-1:0]        r2;
    logic [RAD_W-1:0]        dq;
    logic [50:0]             cr_abs;
    logic signed [51:0]      dt;
    logic [LAT_W-1:0]        lat;
  } front_t;

  typedef struct packed {
    logic                    bv;
    logic                    near;
    logic [50:0]             cr_abs;
    logic signed [51:0]      dt;
    logic [LAT_W-1:0]        lat;
  } sq_side_t;

  typedef struct packed {
    logic                    bv;
    logic                    near;
    logic [LAT_W-1:0]        lat;
    logic [ROOT_W-1:0]       surf_dist;
  } cd_side_t;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ZW-1:0]    z;
  } cord_t;

  function automatic logic signed [ZW-1:0] atan_deg16(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117304);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [33:0] mag35(input logic signed [34:0] v);
    return v[34] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic [33:0] axis_gap(input logic signed [COORD_W-1:0] p,
                                           input logic signed [COORD_W-1:0] lo,
                                           input logic signed [COORD_W-1:0] hi);
    logic [33:0] g;
    if (p < lo) g = 34'(35'(lo) - 35'(p));
    else if (p > hi) g = 34'(35'(p) - 35'(hi));
    else g = '0;
    return g;
  endfunction

  function automatic cord_t cordic_pre(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y);
    cord_t c;
    if (x < 0) begin
      c.x = y;
      c.y = -x;
      c.z = DEG90;
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  function automatic logic [15:0] angle_q8(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] t;
    logic [15:0] a;
    if (z < 0) t = '0;
    else t = (ZW+1)'(z) + (ZW+1)'(128);
    t = t >>> 8;
    if (t > (ZW+1)'(HALF_FULL)) a = HALF_FULL;
    else a = 16'(t);
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sbvt_front.sv
// front stages: geometry, squares, cross terms and lateral gap
`timescale 1ns / 1ps
`default_nettype none
module sbvt_front
  import sbvt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire logic                      in_bv,
  input  wire logic [BOX_W-1:0]          in_box,
  input  wire logic signed [COORD_W-1:0] view_x,
  input  wire logic signed [COORD_W-1:0] view_y,
  input  wire logic signed [COORD_W-1:0] subject_x,
  input  wire logic signed [COORD_W-1:0] subject_y,
  input  wire logic signed [COORD_W-1:0] subject_z,
  input  wire logic signed [15:0]        forward_x,
  input  wire logic signed [15:0]        forward_y,
  output logic                           out_vld,
  output front_t                         out
);

  logic [5:0] vld;
  logic [5:0] bv;

  // stage 1
  logic [BOX_W-1:0] box;
  // stage 2
  logic [33:0] mag [7];
  logic signed [34:0] dnx, dny;
  logic signed [33:0] enx, eny;
  // stage 3
  logic [33:0] pp_hh [7];
  logic [33:0] pp_hl [7];
  logic [33:0] pp_ll [7];
  logic signed [50:0] m_fx_dny, m_fy_dnx, m_fx_dnx, m_fy_dny, m_fy_enx, m_fx_eny;
  // stage 4
  logic [67:0] sq [7];
  logic signed [51:0] cr, dt4, lr;
  // stage 5
  logic [RAD_W-1:0] dist_rad5, r2_5, d2_5;
  logic [50:0] cr_abs5;
  logic signed [51:0] dt5;
  logic [LAT_W-1:0] gq;
  // stage 6
  logic [RAD_W-1:0] dist_rad6, r2_6, dq6;
  logic near6;
  logic [50:0] cr_abs6;
  logic signed [51:0] dt6;
  logic [36:0] ph;
  logic [31:0] pl;

  logic signed [COORD_W-1:0] mnx, mny, mnz, mxx, mxy, mxz;
  logic signed [34:0] d2x_c, d2y_c, e2x_c, e2y_c;
  logic [16:0] afx, afy;
  logic [50:0] cra_c;
  logic signed [52:0] gd_c;

  always_comb begin
    mnx = box[0*COORD_W +: COORD_W];
    mny = box[1*COORD_W +: COORD_W];
    mnz = box[2*COORD_W +: COORD_W];
    mxx = box[3*COORD_W +: COORD_W];
    mxy = box[4*COORD_W +: COORD_W];
    mxz = box[5*COORD_W +: COORD_W];
    d2x_c = 35'(mnx) + 35'(mxx) - (35'(view_x) <<< 1);
    d2y_c = 35'(mny) + 35'(mxy) - (35'(view_y) <<< 1);
    e2x_c = 35'(mxx) - 35'(mnx);
    e2y_c = 35'(mxy) - 35'(mny);
    afx = forward_x[15] ? 17'(-(17'(forward_x))) : 17'(forward_x);
    afy = forward_y[15] ? 17'(-(17'(forward_y))) : 17'(forward_y);
    cra_c = cr[51] ? 51'(-cr) : 51'(cr);
    gd_c = $signed({2'b00, cra_c}) - 53'(lr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld <= {vld[4:0], in_vld};
      out_vld <= vld[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bv <= {bv[4:0], in_bv};
      box <= in_box;

      mag[0] <= axis_gap(subject_x, mnx, mxx);
      mag[1] <= axis_gap(subject_y, mny, mxy);
      mag[2] <= axis_gap(subject_z, mnz, mxz);
      mag[3] <= mag35(e2x_c);
      mag[4] <= mag35(e2y_c);
      mag[5] <= mag35(d2x_c);
      mag[6] <= mag35(d2y_c);
      dnx <= d2x_c;
      dny <= d2y_c;
      enx <= 34'(e2x_c);
      eny <= 34'(e2y_c);

      for (int i = 0; i < 7; i++) begin
        pp_hh[i] <= 34'(mag[i][33:17]) * 34'(mag[i][33:17]);
        pp_hl[i] <= 34'(mag[i][33:17]) * 34'(mag[i][16:0]);
        pp_ll[i] <= 34'(mag[i][16:0]) * 34'(mag[i][16:0]);
      end
      m_fx_dny <= 51'(forward_x) * 51'(dny);
      m_fy_dnx <= 51'(forward_y) * 51'(dnx);
      m_fx_dnx <= 51'(forward_x) * 51'(dnx);
      m_fy_dny <= 51'(forward_y) * 51'(dny);
      m_fy_enx <= 51'($signed({1'b0, afy})) * 51'(enx);
      m_fx_eny <= 51'($signed({1'b0, afx})) * 51'(eny);

      for (int i = 0; i < 7; i++) begin
        sq[i] <= {pp_hh[i], 34'd0} + 68'({pp_hl[i], 18'd0}) + 68'(pp_ll[i]);
      end
      cr  <= 52'(m_fx_dny) - 52'(m_fy_dnx);
      dt4 <= 52'(m_fx_dnx) + 52'(m_fy_dny);
      lr  <= 52'(m_fy_enx) + 52'(m_fx_eny);

      dist_rad5 <= RAD_W'(sq[0]) + RAD_W'(sq[1]) + RAD_W'(sq[2]);
      r2_5      <= RAD_W'(sq[3]) + RAD_W'(sq[4]);
      d2_5      <= RAD_W'(sq[5]) + RAD_W'(sq[6]);
      cr_abs5   <= cra_c;
      dt5       <= dt4;
      gq        <= gd_c[52] ? '0 : LAT_W'(gd_c >>> 15);

      dist_rad6 <= dist_rad5;
      r2_6      <= r2_5;
      dq6       <= d2_5 - r2_5;
      near6     <= d2_5 <= r2_5;
      cr_abs6   <= cr_abs5;
      dt6       <= dt5;
      ph        <= 37'(gq[37:16]) * 37'(K035);
      pl        <= 32'(gq[15:0]) * 32'(K035) + HALF_ROUND;

      out.bv       <= bv[5];
      out.near     <= near6;
      out.dist_rad <= dist_rad6;
      out.r2       <= r2_6;
      out.dq       <= dq6;
      out.cr_abs   <= cr_abs6;
      out.dt       <= dt6;
      out.lat      <= LAT_W'(ph) + LAT_W'(pl[31:16]);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sbvt_sqrt_cell.sv
// one bit of a restoring square root chain
`timescale 1ns / 1ps
`default_nettype none
module sbvt_sqrt_cell
  import sbvt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [5:0]        bitpos,
  input  wire logic [RAD_W-1:0]  rem_in,
  input  wire logic [ROOT_W-1:0] root_in,
  output logic [RAD_W-1:0]       rem,
  output logic [ROOT_W-1:0]      root
);

  logic [RAD_W+1:0] trial, rem_x;
  logic [RAD_W-1:0] rem_next;
  logic [ROOT_W-1:0] root_next;

  always_comb begin
    trial = ({(RAD_W+2-ROOT_W)'(0), root_in} << (bitpos + 6'd1))
          | ((RAD_W+2)'(1) << {bitpos, 1'b0});
    rem_x = {2'b00, rem_in};
    if (trial <= rem_x) begin
      rem_next  = RAD_W'(rem_x - trial);
      root_next = root_in | (ROOT_W'(1) << bitpos);
    end else begin
      rem_next  = rem_in;
      root_next = root_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sbvt_cordic_cell.sv
// one vectoring step of the angle chain
`timescale 1ns / 1ps
`default_nettype none
module sbvt_cordic_cell
  import sbvt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [4:0]           idx,
  input  wire cord_t                cin,
  output cord_t                     cout
);

  logic signed [CW-1:0] xs, ys;
  cord_t c_next;

  always_comb begin
    xs = cin.x >>> idx;
    ys = cin.y >>> idx;
    if (cin.y > 0) begin
      c_next.x = cin.x + ys;
      c_next.y = cin.y - xs;
      c_next.z = cin.z + atan_deg16(idx);
    end else begin
      c_next.x = cin.x - ys;
      c_next.y = cin.y + xs;
      c_next.z = cin.z - atan_deg16(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= c_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sector_box_visibility_test_top.sv
// throughput: one box per cycle, 7 front stages, 35 root cells, 1 pre-rotation,
// 16 angle cells, 1 decision stage and an output register with a skid slot
// the pipeline stalls only while the skid slot is full
// reset: synchronous, active high; clears all valid bits and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "sector_box_visibility_test_top_defines.svh"
module sector_box_visibility_test_top
  import sbvt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z
  input  wire logic [BOX_W-1:0]  s_tdata,
  // box_valid
  input  wire logic              s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // intersects, fully_inside, score, zero pad
  output logic [OUT_W-1:0]       m_tdata,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic signed [COORD_W-1:0] view_x, view_y, subject_x, subject_y, subject_z;
  logic signed [15:0] forward_x, forward_y;
  logic [15:0] half_angle;
  logic en;
  logic skid_vld;
  logic [OUT_W-1:0] skid;

  assign pready = 1'b1;
  assign en = !skid_vld;
  assign s_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view_x <= '0;
      view_y <= '0;
      subject_x <= '0;
      subject_y <= '0;
      subject_z <= '0;
      forward_x <= 16'sd16384;
      forward_y <= '0;
      half_angle <= HALF_FULL;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_VIEW_X:    view_x <= pwdata;
        REG_VIEW_Y:    view_y <= pwdata;
        REG_SUBJECT_X: subject_x <= pwdata;
        REG_SUBJECT_Y: subject_y <= pwdata;
        REG_SUBJECT_Z: subject_z <= pwdata;
        REG_FORWARD_X: forward_x <= pwdata[15:0];
        REG_FORWARD_Y: forward_y <= pwdata[15:0];
        REG_HALF_ANG:  half_angle <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_VIEW_X:    prdata = view_x;
      REG_VIEW_Y:    prdata = view_y;
      REG_SUBJECT_X: prdata = subject_x;
      REG_SUBJECT_Y: prdata = subject_y;
      REG_SUBJECT_Z: prdata = subject_z;
      REG_FORWARD_X: prdata = {16'd0, forward_x};
      REG_FORWARD_Y: prdata = {16'd0, forward_y};
      REG_HALF_ANG:  prdata = {16'd0, half_angle};
    endcase
  end

  // front stages
  logic front_vld;
  front_t front;

  sbvt_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s_tvalid), .in_bv(s_tuser), .in_box(s_tdata),
    .view_x(view_x), .view_y(view_y),
    .subject_x(subject_x), .subject_y(subject_y), .subject_z(subject_z),
    .forward_x(forward_x), .forward_y(forward_y),
    .out_vld(front_vld), .out(front)
  );

  // square root chains
  logic [SQRT_STAGES:0] sq_vld;
  sq_side_t sq_side [SQRT_STAGES+1];
  logic [RAD_W-1:0]  rem_d [SQRT_STAGES+1];
  logic [RAD_W-1:0]  rem_r [SQRT_STAGES+1];
  logic [RAD_W-1:0]  rem_q [SQRT_STAGES+1];
  logic [ROOT_W-1:0] root_d [SQRT_STAGES+1];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES+1];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES+1];

  assign sq_vld[0] = front_vld;
  assign sq_side[0] = '{bv: front.bv, near: front.near, cr_abs: front.cr_abs,
                        dt: front.dt, lat: front.lat};
  assign rem_d[0] = front.dist_rad;
  assign rem_r[0] = front.r2;
  assign rem_q[0] = front.dq;
  assign root_d[0] = '0;
  assign root_r[0] = '0;
  assign root_q[0] = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [5:0] BP = 6'(SQRT_STAGES - 1 - k);

    sbvt_sqrt_cell u_d (.clk(clk), .en(en), .bitpos(BP),
      .rem_in(rem_d[k]), .root_in(root_d[k]), .rem(rem_d[k+1]), .root(root_d[k+1]));
    sbvt_sqrt_cell u_r (.clk(clk), .en(en), .bitpos(BP),
      .rem_in(rem_r[k]), .root_in(root_r[k]), .rem(rem_r[k+1]), .root(root_r[k+1]));
    sbvt_sqrt_cell u_q (.clk(clk), .en(en), .bitpos(BP),
      .rem_in(rem_q[k]), .root_in(root_q[k]), .rem(rem_q[k+1]), .root(root_q[k+1]));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // pre-rotation into the right half plane
  logic [CORDIC_STAGES:0] cd_vld;
  cd_side_t cd_side [CORDIC_STAGES+1];
  cord_t ca [CORDIC_STAGES+1];
  cord_t ar [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_vld[0] <= 1'b0;
    end else if (en) begin
      cd_vld[0] <= sq_vld[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_side[0] <= '{bv: sq_side[SQRT_STAGES].bv, near: sq_side[SQRT_STAGES].near,
                      lat: sq_side[SQRT_STAGES].lat, surf_dist: root_d[SQRT_STAGES]};
      ca[0] <= cordic_pre(CW'(sq_side[SQRT_STAGES].dt),
                          $signed({(CW-51)'(0), sq_side[SQRT_STAGES].cr_abs}));
      ar[0] <= cordic_pre($signed({(CW-ROOT_W)'(0), root_q[SQRT_STAGES]}),
                          $signed({(CW-ROOT_W)'(0), root_r[SQRT_STAGES]}));
    end
  end

  // angle chains
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    localparam logic [4:0] IX = 5'(k);

    sbvt_cordic_cell u_ca (.clk(clk), .en(en), .idx(IX), .cin(ca[k]), .cout(ca[k+1]));
    sbvt_cordic_cell u_ar (.clk(clk), .en(en), .idx(IX), .cin(ar[k]), .cout(ar[k+1]));

    always_ff @(posedge clk) begin
      if (rst) begin
        cd_vld[k+1] <= 1'b0;
      end else if (en) begin
        cd_vld[k+1] <= cd_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cd_side[k+1] <= cd_side[k];
      end
    end
  end

  // decision and score
  cd_side_t fin;
  logic [15:0] ang_c, ang_r;
  logic [16:0] sum_hr, sum_cr;
  logic full, inter, fully;
  logic [SCORE_W:0] sum_score;
  logic [SCORE_W-1:0] score;
  logic [OUT_W-1:0] res_next;

  always_comb begin
    fin = cd_side[CORDIC_STAGES];
    ang_c = angle_q8(ca[CORDIC_STAGES].z);
    ang_r = angle_q8(ar[CORDIC_STAGES].z);
    sum_hr = 17'(half_angle) + 17'(ang_r);
    sum_cr = 17'(ang_c) + 17'(ang_r);
    full = half_angle >= HALF_FULL;
    if (full || fin.near) begin
      inter = 1'b1;
      fully = full;
    end else begin
      inter = 17'(ang_c) <= sum_hr;
      fully = inter && (sum_cr <= 17'(half_angle));
    end
    sum_score = (SCORE_W+1)'(fin.surf_dist) + (SCORE_W+1)'(fin.lat);
    score = sum_score[SCORE_W] ? '1 : sum_score[SCORE_W-1:0];
    if (fin.bv) begin
      res_next = {(OUT_W-SCORE_W-2)'(0), score, fully, inter};
    end else begin
      res_next = '0;
    end
  end

  logic res_vld;
  logic [OUT_W-1:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (en) begin
      res_vld <= cd_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_vld <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (en && res_vld) begin
        skid_vld <= 1'b1;
      end
    end else if (skid_vld) begin
      m_tvalid <= 1'b1;
      skid_vld <= 1'b0;
    end else begin
      m_tvalid <= en && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && !m_tready) begin
      if (en && res_vld) begin
        skid <= res;
      end
    end else if (skid_vld) begin
      m_tdata <= skid;
    end else if (en && res_vld) begin
      m_tdata <= res;
    end
  end

  `SBVT_ASSERT_NOW(a_skid_needs_out, skid_vld, m_tvalid, "skid slot full without output")
  `SBVT_ASSERT_NOW(a_fully_implies_inter, m_tvalid, (!m_tdata[1] || m_tdata[0]),
                   "fully_inside without intersects")
  `SBVT_ASSERT_NEXT(a_skid_drains, (skid_vld && m_tready), (m_tvalid && !skid_vld),
                    "skid slot did not drain")
  `SBVT_ASSERT_NEXT(a_skid_fills, (m_tvalid && !m_tready && res_vld && !skid_vld),
                    skid_vld, "stalled result not held in skid slot")

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// testbench for the sector box visibility test: streams boxes and checks flags and score
`timescale 1ns / 1ps
module testbench
  import sbvt_pkg::*;
();

  typedef struct packed {
    logic            bv;
    logic [5:0][31:0] c;
  } box_t;

  typedef struct packed {
    logic        intersects;
    logic        fully_inside;
    logic [39:0] score;
  } verdict_t;

  localparam int STALL_LIMIT = 3000;
  localparam longint ATAN_TBL [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                       58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                       229, 115};

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [BOX_W-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic signed [31:0] view_x, view_y, subj_x, subj_y, subj_z;
  logic signed [15:0] fwd_x, fwd_y;
  logic [15:0] half_ang;

  verdict_t expected_q[$];
  int errors = 0;
  int stall_cycles = 0;
  bit steady = 0;

  sector_box_visibility_test_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = {64'd0, r | (64'd1 << b)};
      if (t * t <= n) r = t[63:0];
    end
    return r;
  endfunction

  function automatic longint angle_deg_q8(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 90 * 65536;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TBL[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TBL[i];
      end
    end
    if (z < 0) z = 0;
    z = (z + 128) >>> 8;
    if (z > 46080) z = 46080;
    return z;
  endfunction

  function automatic longint gap1(longint p, longint lo, longint hi);
    if (p < lo) return lo - p;
    if (p > hi) return p - hi;
    return 0;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic verdict_t cull_box(box_t b);
    verdict_t v;
    longint mnx, mny, mnz, mxx, mxy, mxz, dx, dy, ex, ey, fx, fy, cr, dt, lr, g, ca, ar;
    logic [127:0] ax, ay, az, r2, d2;
    logic [63:0] lat, total;
    v = '0;
    if (!b.bv) return v;
    mnx = $signed(b.c[0]); mny = $signed(b.c[1]); mnz = $signed(b.c[2]);
    mxx = $signed(b.c[3]); mxy = $signed(b.c[4]); mxz = $signed(b.c[5]);
    fx = fwd_x; fy = fwd_y;
    dx = mnx + mxx - 2 * longint'(view_x);
    dy = mny + mxy - 2 * longint'(view_y);
    ex = mxx - mnx;
    ey = mxy - mny;
    ax = gap1(subj_x, mnx, mxx);
    ay = gap1(subj_y, mny, mxy);
    az = gap1(subj_z, mnz, mxz);
    cr = fx * dy - fy * dx;
    dt = fx * dx + fy * dy;
    lr = mag(fy) * ex + mag(fx) * ey;
    g = mag(cr) - lr;
    if (g < 0) g = 0;
    g = g >>> 15;
    lat = (g >> 16) * 22938 + (((g & 64'hffff) * 22938 + 32768) >> 16);
    total = floor_root(ax * ax + ay * ay + az * az) + lat;
    v.score = (total > 64'hff_ffff_ffff) ? 40'hff_ffff_ffff : total[39:0];
    r2 = 128'(mag(ex)) * 128'(mag(ex)) + 128'(mag(ey)) * 128'(mag(ey));
    d2 = 128'(mag(dx)) * 128'(mag(dx)) + 128'(mag(dy)) * 128'(mag(dy));
    if (half_ang >= 46080 || d2 <= r2) begin
      v.intersects = 1;
      v.fully_inside = (half_ang >= 46080);
    end else begin
      ca = angle_deg_q8(mag(cr), dt);
      ar = angle_deg_q8(longint'(floor_root(r2)), longint'(floor_root(d2 - r2)));
      v.intersects = ca <= longint'(half_ang) + ar;
      v.fully_inside = v.intersects && (ca + ar <= longint'(half_ang));
    end
    return v;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      verdict_t exp_v;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_v = expected_q.pop_front();
        if (m_tdata[0] !== exp_v.intersects) begin
          $error("intersects: expected %0d actual %0d", exp_v.intersects, m_tdata[0]);
          errors++;
        end
        if (m_tdata[1] !== exp_v.fully_inside) begin
          $error("fully_inside: expected %0d actual %0d", exp_v.fully_inside, m_tdata[1]);
          errors++;
        end
        if (m_tdata[41:2] !== exp_v.score) begin
          $error("score: expected %0d actual %0d", exp_v.score, m_tdata[41:2]);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= !rst && (steady || $urandom_range(99) >= 36);
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_sector(logic [31:0] vx, logic [31:0] vy, logic [31:0] sx,
                            logic [31:0] sy, logic [31:0] sz, logic [15:0] fx,
                            logic [15:0] fy, logic [15:0] h);
    drain();
    reg_write(REG_VIEW_X, vx);    view_x = vx;
    reg_write(REG_VIEW_Y, vy);    view_y = vy;
    reg_write(REG_SUBJECT_X, sx); subj_x = sx;
    reg_write(REG_SUBJECT_Y, sy); subj_y = sy;
    reg_write(REG_SUBJECT_Z, sz); subj_z = sz;
    reg_write(REG_FORWARD_X, {16'd0, fx}); fwd_x = fx;
    reg_write(REG_FORWARD_Y, {16'd0, fy}); fwd_y = fy;
    reg_write(REG_HALF_ANG, {16'd0, h});   half_ang = h;
  endtask

  task automatic send_box(box_t b);
    while (!steady && $urandom_range(99) < 36) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= b.c;
    s_tuser <= b.bv;
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(cull_box(b));
  endtask

  function automatic box_t make_box(longint x0, longint y0, longint z0,
                                    longint x1, longint y1, longint z1);
    box_t b;
    b.bv = 1;
    b.c[0] = 32'(x0); b.c[1] = 32'(y0); b.c[2] = 32'(z0);
    b.c[3] = 32'(x1); b.c[4] = 32'(y1); b.c[5] = 32'(z1);
    return b;
  endfunction

  function automatic box_t random_box();
    box_t b;
    longint cx, cy, cz, hx, hy, hz;
    int k, kh;
    if ($urandom_range(99) < 15) begin
      b.bv = 1'($urandom_range(1));
      for (int i = 0; i < 6; i++) b.c[i] = $urandom;
      return b;
    end
    k = $urandom_range(30, 2);
    kh = k - $urandom_range(6, 0);
    if (kh < 0) kh = 0;
    cx = longint'(view_x) + $signed({$urandom, $urandom}) % (64'sd1 << k);
    cy = longint'(view_y) + $signed({$urandom, $urandom}) % (64'sd1 << k);
    cz = $signed({$urandom, $urandom}) % (64'sd1 << k);
    hx = {$urandom, $urandom} % (64'd1 << kh);
    hy = {$urandom, $urandom} % (64'd1 << kh);
    hz = {$urandom, $urandom} % (64'd1 << kh);
    b = make_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
    if ($urandom_range(99) < 8) begin
      b.c[0] = 32'(cx + hx);
      b.c[3] = 32'(cx - hx);
    end
    b.bv = ($urandom_range(99) < 95);
    return b;
  endfunction

  task automatic random_boxes(int n);
    for (int i = 0; i < n; i++) send_box(random_box());
  endtask

  task automatic random_sector();
    real a;
    a = $urandom_range(359) * 3.14159265358979 / 180.0;
    set_sector($urandom_range(4000000) - 2000000, $urandom_range(4000000) - 2000000,
               $urandom, $urandom, $urandom,
               16'($rtoi(16384.0 * $cos(a))), 16'($rtoi(16384.0 * $sin(a))),
               16'($urandom_range(46080)));
  endtask

  task automatic test_directed();
    box_t b;
    set_sector(0, 0, 0, 0, 0, 16'sd16384, 16'd0, 16'd11520);
    b = make_box(100 * 256, -10 * 256, 0, 200 * 256, 10 * 256, 256);
    b.bv = 0;
    send_box(b);
    send_box(make_box(100 * 256, -10 * 256, 0, 200 * 256, 10 * 256, 256));
    send_box(make_box(-200 * 256, -10 * 256, 0, -100 * 256, 10 * 256, 256));
    send_box(make_box(10 * 256, 100 * 256, 0, 20 * 256, 200 * 256, 256));
    send_box(make_box(90 * 256, 50 * 256, 0, 110 * 256, 120 * 256, 256));
    send_box(make_box(-5 * 256, -5 * 256, -5 * 256, 5 * 256, 5 * 256, 5 * 256));
    send_box(make_box(200 * 256, 10 * 256, 0, 100 * 256, -10 * 256, 256));
    send_box(make_box(-2147483648, -2147483648, -2147483648,
                      -2147483648, -2147483648, -2147483648));
    send_box(make_box(2147483647, 2147483647, 2147483647,
                      2147483647, 2147483647, 2147483647));
    send_box(make_box(-2147483648, -2147483648, -2147483648,
                      2147483647, 2147483647, 2147483647));
    send_box(make_box(2147483647, 2147483647, 2147483647,
                      -2147483648, -2147483648, -2147483648));
    b = make_box(-1, -1, -1, -1, -1, -1);
    b.bv = 0;
    send_box(b);
    set_sector(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               16'h0000, 16'h0000, 16'd0);
    send_box(make_box(2147483647, -2147483648, 2147483647,
                      2147483647, -2147483648, 2147483647));
    send_box(make_box(0, 0, 0, 256, 256, 256));
    set_sector(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               16'hc000, 16'hc000, 16'd46080);
    send_box(make_box(-2147483648, 2147483647, -2147483648,
                      -2147483648, 2147483647, -2147483648));
    send_box(make_box(0, 0, 0, 256, 256, 256));
  endtask

  task automatic test_sector_settings();
    set_sector(0, 0, 0, 0, 0, 16'sd16384, 16'd0, 16'd46080);
    random_boxes(150);
    set_sector(0, 0, 0, 0, 0, 16'sd16384, 16'd0, 16'd0);
    random_boxes(120);
    set_sector(1000, -1000, 0, 0, 0, 16'd0, 16'hc000, 16'd5760);
    random_boxes(120);
    set_sector(0, 0, 5000, 5000, 5000, 16'hc000, 16'd0, 16'd23040);
    random_boxes(120);
    set_sector(0, 0, 0, 0, 0, 16'd0, 16'd0, 16'd100);
    random_boxes(80);
    set_sector(0, 0, 0, 0, 0, 16'sd16384, 16'd0, 16'd46079);
    random_boxes(80);
    for (int p = 0; p < 4; p++) begin
      random_sector();
      random_boxes(100);
    end
  endtask

  task automatic test_pause();
    random_sector();
    random_boxes(40);
    s_tvalid <= 0;
    drain();
    steady = 1;
    random_boxes(60);
    steady = 0;
  endtask

  initial begin
    view_x = 0; view_y = 0; subj_x = 0; subj_y = 0; subj_z = 0;
    fwd_x = 16384; fwd_y = 0; half_ang = 46080;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_box(make_box(10 * 256, 0, 0, 20 * 256, 256, 256));
    test_directed();
    test_sector_settings();
    test_pause();
    s_tvalid <= 0;
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sector_box_visibility_test_top.f
+incdir+hdl
hdl/sbvt_pkg.sv
hdl/sbvt_front.sv
hdl/sbvt_sqrt_cell.sv
hdl/sbvt_cordic_cell.sv
hdl/sector_box_visibility_test_top.sv
dv/testbench.sv
